>>> hw/rtl/scytale_pkg.sv
package scytale_pkg;

  localparam int MAX_BYTES = 256;
  localparam int MAX_ROWS  = 64;

  // byte address into the message buffer
  localparam int ADDR_W = $clog2(MAX_BYTES);
  // stored length, 0..MAX_BYTES
  localparam int LEN_W  = $clog2(MAX_BYTES + 1);
  // row count register width
  localparam int ROW_W  = 7;
  // dividend of the column count: length + rows - 1
  localparam int DIV_W  = $clog2(MAX_BYTES + MAX_ROWS);
  localparam int DIV_CNT_W = $clog2(DIV_W);
  // output position and grid index, up to rows * columns
  localparam int POS_W  = $clog2(MAX_BYTES + MAX_ROWS);

  localparam int DATA_W = 8;

  // configuration register indexes
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_DIRECTION = 1'b1;

  // word kinds on the input stream
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // transposition direction
  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_READ
  } scy_state_t;

endpackage

>>> hw/rtl/scytale_transposition_unit.sv
// scytale (columnar transposition) unit. input words are either loads (tuser = 0) of one
// message byte into a 256-byte buffer, with tlast marking the final byte, or fetches
// (tuser = 1) that each return the next transposed byte. every input word yields exactly
// one output word. a fetch during the drain goes first through the synchronous buffer read,
// then lands the byte in the output register. the final load starts a column count
// computation (ceil(length / rows)) on a restoring divider, one quotient bit per cycle,
// followed by a multiply step for the encrypt total; the input is held off meanwhile.
// encrypt reads the row-major grid column by column (rows * cols bytes, zero padding),
// decrypt reads the column-major grid row by row (length bytes). grid indexes are walked
// with row and column counters, no per-byte multiply or divide. row_count and direction
// are sampled at the final load; a row count of 0 acts as 1 and counts above 64 saturate.
module scytale_transposition_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_we,
  input  logic                                   cfg_addr,
  input  logic [scytale_pkg::ROW_W-1:0]          cfg_wdata,
  // input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [scytale_pkg::DATA_W-1:0]         in_tdata,   // [7:0] data_byte
  input  logic                                   in_tuser,   // [0] action
  input  logic                                   in_tlast,   // final_load
  // output stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [scytale_pkg::DATA_W-1:0]         out_tdata,  // [7:0] out_byte
  output logic [1:0]                             out_tuser,  // [0] nothing_left, [1] load_refused
  output logic                                   out_tlast   // last_out
);
  import scytale_pkg::*;

  scy_state_t state_r, state_nxt;

  // configuration registers
  logic [ROW_W-1:0] row_count_r;
  logic             direction_r;

  // message buffer
  logic [DATA_W-1:0] msg_mem [MAX_BYTES];
  logic [DATA_W-1:0] rd_data_r;

  // drain bookkeeping
  logic [LEN_W-1:0] len_r;
  logic             draining_r;
  logic [ROW_W-1:0] rows_used_r;
  logic             dir_used_r;
  logic [LEN_W-1:0] col_total_r;
  logic [POS_W-1:0] enc_total_r;
  logic [POS_W-1:0] pos_r;
  logic [ROW_W-1:0] row_r;
  logic [LEN_W-1:0] col_r;
  logic [POS_W-1:0] idx_r;

  // divider
  logic [DIV_W-1:0]     quo_r;
  logic [ROW_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // pending fetch info for the read cycle
  logic rd_in_range_r;
  logic rd_last_r;

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_none_r;
  logic              out_refused_r;

  logic             in_fire;
  logic             is_fetch;
  logic [POS_W-1:0] drain_total;
  logic             fetch_ok;
  logic [POS_W-1:0] pos_inc;
  logic             fetch_last;
  logic             buf_full;
  logic [LEN_W-1:0] len_after;
  logic [ROW_W-1:0] rows_eff;
  logic [ROW_W:0]   rem_sh;
  logic             rem_ge;
  logic             out_free;

  // ---------------------------------------------------------------------------
  // control decode
  // ---------------------------------------------------------------------------
  assign in_fire     = in_tvalid && in_tready;
  assign is_fetch    = (in_tuser == ACT_FETCH);
  assign drain_total = (dir_used_r == DIR_DECRYPT) ? POS_W'(len_r) : enc_total_r;
  assign fetch_ok    = draining_r && (pos_r < drain_total);
  assign pos_inc     = pos_r + POS_W'(1);
  assign fetch_last  = (pos_inc >= drain_total);
  assign buf_full    = (len_r >= LEN_W'(MAX_BYTES));
  assign len_after   = buf_full ? len_r : len_r + LEN_W'(1);
  assign out_free    = !out_valid_r || out_tready;

  // saturate the row count into 1..MAX_ROWS
  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = ROW_W'(1);
    end else if (row_count_r > ROW_W'(MAX_ROWS)) begin
      rows_eff = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff = row_count_r;
    end
  end

  // restoring divide step: one quotient bit a cycle
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, rows_used_r});

  // ---------------------------------------------------------------------------
  // state machine
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!is_fetch && !draining_r && in_tlast) begin
            state_nxt = ST_DIV;
          end else if (is_fetch && fetch_ok) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_IDLE;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_IDLE: in_tready = out_free;
      default: in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_W'(4);
      direction_r <= DIR_ENCRYPT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROW_COUNT: row_count_r <= cfg_wdata;
        REG_DIRECTION: direction_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // message buffer: one write port for loads, one registered read port for fetches
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire && !is_fetch && !draining_r && !buf_full) begin
      msg_mem[len_r[ADDR_W-1:0]] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= msg_mem[idx_r[ADDR_W-1:0]];
  end

  // ---------------------------------------------------------------------------
  // load / drain bookkeeping
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      draining_r  <= 1'b0;
      pos_r       <= '0;
      rows_used_r <= ROW_W'(4);
      dir_used_r  <= DIR_ENCRYPT;
      col_total_r <= '0;
      enc_total_r <= '0;
      div_cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire && !is_fetch && !draining_r) begin
            len_r <= len_after;
            if (in_tlast) begin
              // sample the settings and start ceil(len / rows)
              rows_used_r <= rows_eff;
              dir_used_r  <= direction_r;
              div_cnt_r   <= '0;
              pos_r       <= '0;
              draining_r  <= 1'b1;
            end
          end else if (in_fire && is_fetch && draining_r) begin
            if (!fetch_ok || fetch_last) begin
              // message done, back to loading with an empty buffer
              draining_r <= 1'b0;
              len_r      <= '0;
              pos_r      <= '0;
            end else begin
              pos_r <= pos_inc;
            end
          end
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
          if (div_cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
            col_total_r <= LEN_W'({quo_r[DIV_W-2:0], rem_ge});
          end
        end
        ST_MUL: begin
          enc_total_r <= POS_W'(rows_used_r * col_total_r);
        end
        default: ;
      endcase
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      quo_r <= DIV_W'(len_after) + DIV_W'(rows_eff) - DIV_W'(1);
      rem_r <= '0;
    end else if (state_r == ST_DIV) begin
      quo_r <= {quo_r[DIV_W-2:0], rem_ge};
      rem_r <= rem_ge ? ROW_W'(rem_sh - {1'b0, rows_used_r}) : ROW_W'(rem_sh);
    end
  end

  // grid walk: idx follows the transposed order with row and column counters
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      row_r <= '0;
      col_r <= '0;
      idx_r <= '0;
    end else if (state_r == ST_IDLE && in_fire && is_fetch && fetch_ok) begin
      if (dir_used_r == DIR_ENCRYPT) begin
        // down a column, then on to the top of the next one
        if (row_r == rows_used_r - ROW_W'(1)) begin
          row_r <= '0;
          col_r <= col_r + LEN_W'(1);
          idx_r <= POS_W'(col_r) + POS_W'(1);
        end else begin
          row_r <= row_r + ROW_W'(1);
          idx_r <= idx_r + POS_W'(col_total_r);
        end
      end else begin
        // along a row, then on to the start of the next one
        if (col_r == col_total_r - LEN_W'(1)) begin
          col_r <= '0;
          row_r <= row_r + ROW_W'(1);
          idx_r <= POS_W'(row_r) + POS_W'(1);
        end else begin
          col_r <= col_r + LEN_W'(1);
          idx_r <= idx_r + POS_W'(rows_used_r);
        end
      end
    end
  end

  // fetch context carried into the read cycle
  always_ff @(posedge clk) begin
    if (in_fire && is_fetch) begin
      rd_in_range_r <= (idx_r < POS_W'(len_r));
      rd_last_r     <= fetch_last;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_READ) begin
      out_valid_r <= 1'b1;
    end else if (in_fire && !(is_fetch && fetch_ok)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      // padding cells past the stored length read as zero
      out_byte_r    <= rd_in_range_r ? rd_data_r : '0;
      out_last_r    <= rd_last_r;
      out_none_r    <= 1'b0;
      out_refused_r <= 1'b0;
    end else if (in_fire && !(is_fetch && fetch_ok)) begin
      out_byte_r    <= '0;
      out_last_r    <= 1'b0;
      out_none_r    <= is_fetch;
      out_refused_r <= !is_fetch && (draining_r || buf_full);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_refused_r, out_none_r};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> out_valid_r)
    else $error("fetch read did not reach the output register");

  a_flag_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_none_r || out_refused_r) |-> out_byte_r == '0 && !out_last_r)
    else $error("flag word carries a data byte or last marker");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_BYTES))
    else $error("stored length beyond buffer capacity");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r && state_r == ST_IDLE && $past(state_r) == ST_IDLE |-> pos_r <= drain_total)
    else $error("drain position past the drain total");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_MUL) |-> !in_tready)
    else $error("input accepted while the column count is computed");

endmodule
